FILE: rtl/pdmd_pkg.sv
// ----------------------------------------------------------------------------
// PD motor drive package
// Shared types, constants and the control store of the position drive.
// ----------------------------------------------------------------------------
package pdmd_pkg;

  // Angle limits in 1/256 degree, 24-bit signed.
  localparam logic signed [23:0] POS_MAX = 24'sh7FFFFF;
  localparam logic signed [23:0] POS_MIN = 24'sh800000;

  // Configuration register indexes.
  localparam logic [2:0] REG_DEG_PER_COUNT = 3'd0;
  localparam logic [2:0] REG_INVERT_DIR    = 3'd1;
  localparam logic [2:0] REG_PROP_GAIN     = 3'd2;
  localparam logic [2:0] REG_DERIV_GAIN    = 3'd3;
  localparam logic [2:0] REG_MAX_DUTY      = 3'd4;
  localparam logic [2:0] REG_DEADBAND      = 3'd5;

  localparam logic [7:0] MAX_DUTY_RESET = 8'd255;

  // Program step addresses.
  typedef logic [2:0] step_t;
  localparam step_t ST_IDLE = 3'd0;
  localparam step_t ST_MPOS = 3'd1;
  localparam step_t ST_ERR  = 3'd2;
  localparam step_t ST_MP   = 3'd3;
  localparam step_t ST_MD   = 3'd4;
  localparam step_t ST_OUT  = 3'd5;

  // Operand selection of the shared multiplier.
  typedef enum logic [1:0] {
    MUL_NONE,
    MUL_POS,
    MUL_PROP,
    MUL_DERIV
  } mul_sel_e;

  // Branch kinds of the sequencer.
  typedef enum logic [1:0] {
    BR_NEXT,
    BR_TAKE,
    BR_EMIT
  } br_e;

  // One control word.
  typedef struct packed {
    mul_sel_e mul;
    logic     err_en;
    logic     dlt_en;
    logic     acc_en;
    br_e      br;
    step_t    tgt;
  } uword_t;

  // Per-cycle control from the sequencer to the datapath.
  typedef struct packed {
    mul_sel_e mul;
    logic     err_en;
    logic     dlt_en;
    logic     acc_en;
    logic     load;
    logic     emit;
  } ctrl_t;

  // Configuration register file contents.
  typedef struct packed {
    logic [23:0] deg_per_count;
    logic        invert_direction;
    logic [15:0] prop_gain;
    logic [15:0] deriv_gain;
    logic [7:0]  max_duty;
    logic [15:0] deadband;
  } cfg_t;

  // One result item.
  typedef struct packed {
    logic [7:0] forward_duty;
    logic [7:0] reverse_duty;
    logic       in_deadband;
  } res_t;

  // Control store: the program run for every control tick.
  function automatic uword_t ucode_rom(input step_t step);
    uword_t w;
    w = '{mul: MUL_NONE, err_en: 1'b0, dlt_en: 1'b0, acc_en: 1'b0,
          br: BR_NEXT, tgt: ST_IDLE};
    unique case (step)
      ST_IDLE: begin
        w.br  = BR_TAKE;
        w.tgt = ST_MPOS;
      end
      ST_MPOS: w.mul = MUL_POS;
      ST_ERR:  w.err_en = 1'b1;
      ST_MP: begin
        w.mul    = MUL_PROP;
        w.dlt_en = 1'b1;
      end
      ST_MD: begin
        w.mul    = MUL_DERIV;
        w.acc_en = 1'b1;
      end
      ST_OUT: begin
        w.br  = BR_EMIT;
        w.tgt = ST_MPOS;
      end
      default: begin
        w.br  = BR_TAKE;
        w.tgt = ST_MPOS;
      end
    endcase
    return w;
  endfunction

endpackage

FILE: rtl/pdmd_seq.sv
// ----------------------------------------------------------------------------
// PD motor drive sequencer
// Step counter over the control store, with wait-for-input and
// wait-for-output branches; drives the datapath through one control word.
// ----------------------------------------------------------------------------
module pdmd_seq (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           out_free_i,
  output logic           in_ready_o,
  output pdmd_pkg::ctrl_t ctrl_o
);
  import pdmd_pkg::*;

  step_t  step_q, step_d;
  uword_t word;
  logic   take;

  assign word = ucode_rom(step_q);

  // A new item is taken while idle, or while the result leaves the block.
  assign in_ready_o = (word.br == BR_TAKE) || ((word.br == BR_EMIT) && out_free_i);
  assign take       = in_ready_o && in_valid_i;

  // Control word fanout.
  always_comb begin
    ctrl_o.mul    = word.mul;
    ctrl_o.err_en = word.err_en;
    ctrl_o.dlt_en = word.dlt_en;
    ctrl_o.acc_en = word.acc_en;
    ctrl_o.load   = take;
    ctrl_o.emit   = (word.br == BR_EMIT) && out_free_i;
  end

  // Next step address.
  always_comb begin
    step_d = step_q;
    unique case (word.br)
      BR_NEXT: step_d = step_q + 3'd1;
      BR_TAKE: if (in_valid_i) begin
        step_d = word.tgt;
      end
      BR_EMIT: if (out_free_i) begin
        step_d = in_valid_i ? word.tgt : ST_IDLE;
      end
      default: step_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= ST_IDLE;
    end else begin
      step_q <= step_d;
    end
  end

endmodule

FILE: rtl/pdmd_dpath.sv
// ----------------------------------------------------------------------------
// PD motor drive datapath
// Input registers, one shared multiplier, error and delta registers,
// accumulator and the clamp/deadband output logic.
// ----------------------------------------------------------------------------
module pdmd_dpath (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  pdmd_pkg::ctrl_t       ctrl_i,
  input  pdmd_pkg::cfg_t        cfg_i,
  input  logic signed [23:0]    target_angle_i,
  input  logic signed [31:0]    encoder_count_i,
  output pdmd_pkg::res_t        res_o
);
  import pdmd_pkg::*;

  logic signed [23:0] target_q;
  logic signed [31:0] count_q;
  logic signed [57:0] prod_q;
  logic signed [42:0] acc_q;
  logic signed [23:0] err_q, err_d;
  logic signed [23:0] last_q;
  logic signed [24:0] delta_q;

  logic        [31:0] cmag;
  logic signed [32:0] mul_a;
  logic signed [24:0] mul_b;
  logic signed [57:0] mul_p;

  logic        [47:0] pmag;
  logic               pneg;
  logic signed [23:0] pos;
  logic signed [24:0] diff;

  logic signed [42:0] sum;
  logic        [42:0] smag;
  logic        [26:0] shifted;
  logic        [7:0]  mag;
  logic        [23:0] emag;
  logic               indb;

  // Magnitude of the encoder count; the sign is applied after scaling.
  assign cmag = count_q[31] ? (~count_q + 32'd1) : count_q;

  // Shared multiplier operand selection.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (ctrl_i.mul)
      MUL_POS: begin
        mul_a = {1'b0, cmag};
        mul_b = {1'b0, cfg_i.deg_per_count};
      end
      MUL_PROP: begin
        mul_a = {17'd0, cfg_i.prop_gain};
        mul_b = {err_q[23], err_q};
      end
      MUL_DERIV: begin
        mul_a = {17'd0, cfg_i.deriv_gain};
        mul_b = delta_q;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // Scaled position, saturated, then the saturated error against the target.
  always_comb begin
    pmag = prod_q[55:8];
    pneg = count_q[31] ^ cfg_i.invert_direction;
    if (pneg) begin
      pos = (pmag > 48'd8388608) ? POS_MIN : (~pmag[23:0] + 24'd1);
    end else begin
      pos = (pmag > 48'd8388607) ? POS_MAX : pmag[23:0];
    end
    diff = {target_q[23], target_q} - {pos[23], pos};
    if (diff[24] != diff[23]) begin
      err_d = diff[24] ? POS_MIN : POS_MAX;
    end else begin
      err_d = diff[23:0];
    end
  end

  // Drive sum, clamp and deadband.
  always_comb begin
    sum     = acc_q + prod_q[42:0];
    smag    = sum[42] ? (~sum + 43'd1) : sum;
    shifted = smag[42:16];
    mag     = (shifted > {19'd0, cfg_i.max_duty}) ? cfg_i.max_duty : shifted[7:0];
    emag    = err_q[23] ? (~err_q + 24'd1) : err_q;
    indb    = emag < {8'd0, cfg_i.deadband};
    res_o.in_deadband  = indb;
    res_o.forward_duty = (indb || sum[42]) ? 8'd0 : mag;
    res_o.reverse_duty = (indb || !sum[42]) ? 8'd0 : mag;
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      target_q <= target_angle_i;
      count_q  <= encoder_count_i;
    end
    if (ctrl_i.mul != MUL_NONE) begin
      prod_q <= mul_p;
    end
    if (ctrl_i.err_en) begin
      err_q <= err_d;
    end
    if (ctrl_i.dlt_en) begin
      delta_q <= {err_q[23], err_q} - {last_q[23], last_q};
    end
    if (ctrl_i.acc_en) begin
      acc_q <= prod_q[42:0];
    end
  end

  // Previous error is architectural state and resets to zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q <= '0;
    end else if (ctrl_i.dlt_en) begin
      last_q <= err_q;
    end
  end

endmodule

FILE: rtl/pd_position_motor_drive.sv
// ----------------------------------------------------------------------------
// PD position motor drive
// PD controller with deadband and saturation for one joint, run by a small
// microcoded sequencer over one shared multiplier.
//
//   Channel   Direction  Contents (low bit first)
//   s_axis    in         target_angle[23:0], encoder_count[55:24]
//   m_axis    out        tdata: forward_duty[7:0], reverse_duty[15:8];
//                        tuser: in_deadband
//   cfg       in         write enable, register index, 24-bit data
//
// An item runs through five program steps from its input transfer to its
// result (three of them products on the one multiplier).
// The next input transfer is taken in the cycle the result is registered,
// so a new item is taken only once the last one is through.
// A result waits in the output register while m_axis_tready is low; the
// program holds in its last step until that register is free.
// Reset restores the register defaults and clears the previous error.
// ----------------------------------------------------------------------------
module pd_position_motor_drive (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [55:0] s_axis_tdata,   // target_angle[23:0], encoder_count[55:24]
  // Output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // forward_duty[7:0], reverse_duty[15:8]
  output logic        m_axis_tuser,   // in_deadband
  // Configuration write port
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [23:0] cfg_data_i
);
  import pdmd_pkg::*;

  cfg_t  cfg_q;
  ctrl_t ctrl;
  res_t  res;
  res_t  out_q;
  logic  out_valid_q;
  logic  out_free;

  assign out_free = !out_valid_q || m_axis_tready;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.deg_per_count    <= '0;
      cfg_q.invert_direction <= 1'b0;
      cfg_q.prop_gain        <= '0;
      cfg_q.deriv_gain       <= '0;
      cfg_q.max_duty         <= MAX_DUTY_RESET;
      cfg_q.deadband         <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_DEG_PER_COUNT: cfg_q.deg_per_count    <= cfg_data_i;
        REG_INVERT_DIR:    cfg_q.invert_direction <= cfg_data_i[0];
        REG_PROP_GAIN:     cfg_q.prop_gain        <= cfg_data_i[15:0];
        REG_DERIV_GAIN:    cfg_q.deriv_gain       <= cfg_data_i[15:0];
        REG_MAX_DUTY:      cfg_q.max_duty         <= cfg_data_i[7:0];
        REG_DEADBAND:      cfg_q.deadband         <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  pdmd_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .out_free_i (out_free),
    .in_ready_o (s_axis_tready),
    .ctrl_o     (ctrl)
  );

  pdmd_dpath u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .ctrl_i          (ctrl),
    .cfg_i           (cfg_q),
    .target_angle_i  (s_axis_tdata[23:0]),
    .encoder_count_i (s_axis_tdata[55:24]),
    .res_o           (res)
  );

  // Output register: valid flag under reset, payload loaded on emit.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl.emit) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.emit) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_q.reverse_duty, out_q.forward_duty};
  assign m_axis_tuser  = out_q.in_deadband;

endmodule

FILE: rtl/pdmd_checker.sv
// ----------------------------------------------------------------------------
// PD motor drive port checker
// Watches the ports of the position drive and flags illegal behavior.
// ----------------------------------------------------------------------------
module pdmd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic        m_axis_tuser
);

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  // The program runs four steps after an input transfer before it can take another.
  a_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=>
      !s_axis_tready ##1 !s_axis_tready ##1 !s_axis_tready ##1 !s_axis_tready)
    else $error("input taken while a tick is in progress");

  // Inside the deadband both bridge duties are zero.
  a_deadband_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == 16'd0)
    else $error("drive outside zero in deadband");

  // The bridge is never driven both ways at once.
  a_one_direction: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[7:0] == 8'd0) || (m_axis_tdata[15:8] == 8'd0))
    else $error("forward and reverse duty both nonzero");

endmodule

bind pd_position_motor_drive pdmd_checker u_pdmd_checker (.*);
